FILE: hdl/adc_moving_average_to_angle_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ADC_MOVING_AVERAGE_TO_ANGLE_MACROS_SVH
`define ADC_MOVING_AVERAGE_TO_ANGLE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define AMAA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("amaa check failed");

// next-cycle implication
`define AMAA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("amaa check failed");

`else

`define AMAA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define AMAA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/amaa_pkg.sv
`timescale 1ns / 1ps

package amaa_pkg;

    // clamp window and angle mapping
    localparam int CLAMP_LO     = 30;
    localparam int CLAMP_HI     = 4050;
    localparam int ANGLE_OFFSET = 35;

    // 70 / 4020 reduces to 7 / 402
    localparam int ANGLE_NUM    = 7;
    localparam int ANGLE_DEN    = 402;

    // floor(d * 7 / 402) approximated as (d * RECIP_MULT) >> RECIP_SHIFT, low by at most one
    localparam int RECIP_SHIFT  = 20;
    localparam int RECIP_MULT   = (ANGLE_NUM << RECIP_SHIFT) / ANGLE_DEN;

    localparam int CLAMP_W      = 12;  // clamped value minus CLAMP_LO, 0..4020
    localparam int RECIP_W      = 15;
    localparam int PROD_W       = CLAMP_W + RECIP_W;
    localparam int QUOT_W       = 7;   // 0..70
    localparam int REM_W        = 16;
    localparam int ANGLE_W      = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_ANG_MUL,
        ST_ANG_FIX,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic update;
        logic div_step;
        logic ang_mul;
        logic ang_fix;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } status_t;

endpackage

FILE: hdl/adc_moving_average_to_angle.sv
// Moving-average filter over WINDOW_LEN ADC samples with conversion of the mean, or of the
// raw sample when use_average is 0, to a steering angle of -35..35 degrees after clamping
// to 30..4050. Each accepted sample gives exactly one result, and no new sample is taken
// until that result has gone into the output register. The mean comes from a bit-serial
// divider, one quotient bit per cycle. The result sits in an output register, so a new
// sample is taken while the previous result still waits; a stalled result holds off only
// the final load of the next one. use_average resets to 1; the user must write it only
// while idle, as the block itself does not enforce this.
`timescale 1ns / 1ps
`include "adc_moving_average_to_angle_macros.svh"

module adc_moving_average_to_angle
#(
    parameter int WINDOW_LEN  = 5,
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic                                cfg_data,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic [SAMPLE_BITS-1:0]              sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [SAMPLE_BITS-1:0]              mean_value,
    output logic signed [amaa_pkg::ANGLE_W-1:0] angle_deg
);

    amaa_pkg::cmd_t    cmd;
    amaa_pkg::status_t status;

    amaa_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    amaa_dp
    #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .sample     (sample),
        .mean_value (mean_value),
        .angle_deg  (angle_deg)
    );

    // a new result never overwrites one that is still held
    `AMAA_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.out_load, !result_valid || !result_stall)
    // no second sample while one is in flight
    `AMAA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, sample_valid && !sample_stall, sample_stall)
    // angle mapping starts only on a finished quotient
    `AMAA_ASSERT_SAME(a_div_finished, clk, rst_n, cmd.ang_mul, status.div_done)
    // delivered angle stays in range
    `AMAA_ASSERT_SAME(a_angle_range, clk, rst_n, result_valid, angle_deg >= -7'sd35 && angle_deg <= 7'sd35)

endmodule

FILE: hdl/amaa_ctrl.sv
`timescale 1ns / 1ps

module amaa_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    output logic               result_valid,
    input  logic               result_stall,
    input  amaa_pkg::status_t  status,
    output amaa_pkg::cmd_t     cmd
);

    amaa_pkg::state_t state_reg;
    amaa_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= amaa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output register is free if empty or emptied by a transfer this cycle
    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            amaa_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = amaa_pkg::ST_UPDATE;
                end
            end
            amaa_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = amaa_pkg::ST_DIV;
            end
            amaa_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = amaa_pkg::ST_ANG_MUL;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            amaa_pkg::ST_ANG_MUL:
            begin
                cmd.ang_mul = 1'b1;
                state_next  = amaa_pkg::ST_ANG_FIX;
            end
            amaa_pkg::ST_ANG_FIX:
            begin
                cmd.ang_fix = 1'b1;
                state_next  = amaa_pkg::ST_FINISH;
            end
            amaa_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = amaa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = amaa_pkg::ST_IDLE;
            end
        endcase
    end

    assign sample_stall = (state_reg != amaa_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;

endmodule

FILE: hdl/amaa_dp.sv
`timescale 1ns / 1ps

module amaa_dp
#(
    parameter int WINDOW_LEN  = 5,
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  amaa_pkg::cmd_t                cmd,
    output amaa_pkg::status_t             status,
    input  logic                          cfg_write,
    input  logic                          cfg_data,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output logic [SAMPLE_BITS-1:0]        mean_value,
    output logic signed [amaa_pkg::ANGLE_W-1:0] angle_deg
);

    localparam int PTR_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int DCNT_W  = $clog2(SUM_W + 1);
    localparam int VX_W    = (SAMPLE_BITS > amaa_pkg::CLAMP_W) ? SAMPLE_BITS : amaa_pkg::CLAMP_W;

    logic [SAMPLE_BITS-1:0] window_mem [WINDOW_LEN];

    // control-side state
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [PTR_W-1:0]   wp_reg;
    logic [PTR_W-1:0]   wp_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic [DCNT_W-1:0]  div_cnt_reg;
    logic [DCNT_W-1:0]  div_cnt_next;
    logic               use_average_reg;
    logic               use_average_next;

    // payload
    logic [SAMPLE_BITS-1:0]        sample_reg;
    logic [SAMPLE_BITS-1:0]        old_reg;
    logic [CNT_W-1:0]              rem_reg;
    logic [CNT_W-1:0]              rem_next;
    logic [SUM_W-1:0]              quo_reg;
    logic [SUM_W-1:0]              quo_next;
    logic [amaa_pkg::CLAMP_W-1:0]  span_reg;
    logic [amaa_pkg::PROD_W-1:0]   prod_reg;
    logic [amaa_pkg::ANGLE_W-1:0]  angle_reg;
    logic [SAMPLE_BITS-1:0]        mean_value_reg;
    logic [amaa_pkg::ANGLE_W-1:0]  angle_deg_reg;

    logic [SAMPLE_BITS-1:0]        old_eff;
    logic [CNT_W:0]                trial;
    logic                          trial_ge;
    logic [SAMPLE_BITS-1:0]        mean;
    logic [SAMPLE_BITS-1:0]        sel_value;
    logic [VX_W-1:0]               sel_ext;
    logic [VX_W-1:0]               clamped;
    logic [VX_W-1:0]               span_wide;
    logic [amaa_pkg::CLAMP_W-1:0]  span;
    logic [amaa_pkg::QUOT_W-1:0]   quot0;
    logic [amaa_pkg::REM_W-1:0]    rem_ang;
    logic [amaa_pkg::QUOT_W-1:0]   quot;

    // entry being replaced counts as zero until the window is full
    assign old_eff = (fill_reg == CNT_W'(WINDOW_LEN)) ? old_reg : '0;

    always_comb
    begin
        sum_next         = sum_reg;
        wp_next          = wp_reg;
        fill_next        = fill_reg;
        div_cnt_next     = div_cnt_reg;
        use_average_next = use_average_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        trial            = {rem_reg, quo_reg[SUM_W-1]};
        trial_ge         = (trial >= {1'b0, fill_reg});

        if (cfg_write)
        begin
            use_average_next = cfg_data;
        end
        if (cmd.update)
        begin
            sum_next = sum_reg - SUM_W'(old_eff) + SUM_W'(sample_reg);
            if (wp_reg == PTR_W'(WINDOW_LEN - 1))
            begin
                wp_next = '0;
            end
            else
            begin
                wp_next = wp_reg + PTR_W'(1);
            end
            if (fill_reg != CNT_W'(WINDOW_LEN))
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
            rem_next     = '0;
            quo_next     = sum_next;
            div_cnt_next = DCNT_W'(SUM_W);
        end
        if (cmd.div_step)
        begin
            // restoring division, one quotient bit per cycle
            if (trial_ge)
            begin
                rem_next = CNT_W'(trial - {1'b0, fill_reg});
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
            end
            quo_next     = {quo_reg[SUM_W-2:0], trial_ge};
            div_cnt_next = div_cnt_reg - DCNT_W'(1);
        end
    end

    assign status.div_done = (div_cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg         <= '0;
            wp_reg          <= '0;
            fill_reg        <= '0;
            div_cnt_reg     <= '0;
            use_average_reg <= 1'b1;
        end
        else
        begin
            sum_reg         <= sum_next;
            wp_reg          <= wp_next;
            fill_reg        <= fill_next;
            div_cnt_reg     <= div_cnt_next;
            use_average_reg <= use_average_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            old_reg <= window_mem[wp_reg];
        end
        if (cmd.update)
        begin
            window_mem[wp_reg] <= sample_reg;
        end
    end

    // angle: clamp, then floor((v - 30) * 7 / 402) - 35
    assign mean      = quo_reg[SAMPLE_BITS-1:0];
    assign sel_value = use_average_reg ? mean : sample_reg;
    assign sel_ext   = VX_W'(sel_value);

    always_comb
    begin
        if (sel_ext < VX_W'(amaa_pkg::CLAMP_LO))
        begin
            clamped = VX_W'(amaa_pkg::CLAMP_LO);
        end
        else if (sel_ext > VX_W'(amaa_pkg::CLAMP_HI))
        begin
            clamped = VX_W'(amaa_pkg::CLAMP_HI);
        end
        else
        begin
            clamped = sel_ext;
        end
    end

    assign span_wide = clamped - VX_W'(amaa_pkg::CLAMP_LO);
    assign span      = span_wide[amaa_pkg::CLAMP_W-1:0];

    assign quot0   = prod_reg[amaa_pkg::RECIP_SHIFT +: amaa_pkg::QUOT_W];
    assign rem_ang = amaa_pkg::REM_W'(span_reg) * amaa_pkg::REM_W'(amaa_pkg::ANGLE_NUM)
                   - amaa_pkg::REM_W'(quot0) * amaa_pkg::REM_W'(amaa_pkg::ANGLE_DEN);
    assign quot    = (rem_ang >= amaa_pkg::REM_W'(amaa_pkg::ANGLE_DEN))
                   ? quot0 + amaa_pkg::QUOT_W'(1) : quot0;

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.load)
        begin
            sample_reg <= sample;
        end
        if (cmd.ang_mul)
        begin
            span_reg <= span;
            prod_reg <= amaa_pkg::PROD_W'(span)
                      * amaa_pkg::PROD_W'(amaa_pkg::RECIP_MULT);
        end
        if (cmd.ang_fix)
        begin
            angle_reg <= quot - amaa_pkg::ANGLE_W'(amaa_pkg::ANGLE_OFFSET);
        end
        if (cmd.out_load)
        begin
            mean_value_reg <= mean;
            angle_deg_reg  <= angle_reg;
        end
    end

    assign mean_value = mean_value_reg;
    assign angle_deg  = $signed(angle_deg_reg);

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int WIN         = 5;
    localparam int SW          = 12;
    localparam int SMP_MAX     = (1 << SW) - 1;
    localparam int MAX_GAP     = 12;
    localparam int SETTLE      = 40;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 210;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DIR_N       = 24;

    typedef struct packed {
        logic [SW-1:0]                        mean;
        logic signed [amaa_pkg::ANGLE_W-1:0]  angle;
    } avg_result_t;

    typedef struct {
        bit avg;
        int smp;
        bit typed;
        int mean;
        int angle;
    } dir_row_t;

    // averaging mode, sample, whether the result is typed in, mean, angle
    dir_row_t dir_rows [0:DIR_N-1] = '{
        '{1'b1, 0,       1'b1, 0,    -35},
        '{1'b1, 0,       1'b1, 0,    -35},
        '{1'b1, 4095,    1'b0, 0,    0},
        '{1'b1, 4095,    1'b0, 0,    0},
        '{1'b1, 4095,    1'b0, 0,    0},
        '{1'b1, 4095,    1'b0, 0,    0},
        '{1'b1, 4095,    1'b1, 4095, 35},
        '{1'b1, 4095,    1'b1, 4095, 35},
        '{1'b0, 4095,    1'b1, 4095, 35},
        '{1'b0, 0,       1'b1, 3276, -35},
        '{1'b0, 29,      1'b0, 0,    0},
        '{1'b0, 30,      1'b0, 0,    0},
        '{1'b0, 31,      1'b0, 0,    0},
        '{1'b0, 4049,    1'b0, 0,    0},
        '{1'b0, 4050,    1'b0, 0,    0},
        '{1'b0, 4051,    1'b0, 0,    0},
        '{1'b0, 'hAAA,   1'b0, 0,    0},
        '{1'b0, 'h555,   1'b0, 0,    0},
        '{1'b1, 2040,    1'b0, 0,    0},
        '{1'b1, 2040,    1'b0, 0,    0},
        '{1'b1, 2040,    1'b0, 0,    0},
        '{1'b1, 2040,    1'b0, 0,    0},
        '{1'b1, 2040,    1'b1, 2040, 0},
        '{1'b1, 'h800,   1'b0, 0,    0}
    };

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_write = 1'b0;
    logic                                 cfg_data = 1'b0;
    logic                                 sample_valid = 1'b0;
    logic                                 sample_stall;
    logic [SW-1:0]                        sample = '0;
    logic                                 result_valid;
    logic                                 result_stall = 1'b0;
    logic [SW-1:0]                        mean_value;
    logic signed [amaa_pkg::ANGLE_W-1:0]  angle_deg;

    // filter state mirrored on the testbench side
    logic [SW-1:0]  win_q [WIN] = '{default: '0};
    int             wr_idx = 0;
    int             held = 0;
    int             sum_acc = 0;
    bit             avg_mode = 1'b1;

    avg_result_t    pending_results [$];
    int             mismatch_count = 0;
    int             cycle_count = 0;
    int             stall_left = 0;
    bit             tx_quiet = 1'b0;
    bit             rx_quiet = 1'b0;

    adc_moving_average_to_angle #(
        .WINDOW_LEN  (WIN),
        .SAMPLE_BITS (SW)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .mean_value   (mean_value),
        .angle_deg    (angle_deg)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic signed [amaa_pkg::ANGLE_W-1:0] to_angle(int v);
        int x;
        x = (v < amaa_pkg::CLAMP_LO) ? amaa_pkg::CLAMP_LO
          : ((v > amaa_pkg::CLAMP_HI) ? amaa_pkg::CLAMP_HI : v);
        return amaa_pkg::ANGLE_W'((x - amaa_pkg::CLAMP_LO) * (2 * amaa_pkg::ANGLE_OFFSET)
                                  / (amaa_pkg::CLAMP_HI - amaa_pkg::CLAMP_LO)
                                  - amaa_pkg::ANGLE_OFFSET);
    endfunction

    // advance the window by one sample and form mean and angle
    function automatic avg_result_t filter_predict(logic [SW-1:0] s);
        avg_result_t r;
        int m;
        sum_acc = sum_acc - int'(win_q[wr_idx]) + int'(s);
        win_q[wr_idx] = s;
        wr_idx = (wr_idx + 1) % WIN;
        if (held < WIN)
            held++;
        m = sum_acc / held;
        r.mean = SW'(m);
        r.angle = to_angle(avg_mode ? m : int'(s));
        return r;
    endfunction

    function automatic int pick_level();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return SMP_MAX;
            2: return $urandom_range(0, 2 * amaa_pkg::CLAMP_LO);
            3: return $urandom_range(amaa_pkg::CLAMP_HI - 30, SMP_MAX);
            default: return $urandom_range(0, SMP_MAX);
        endcase
    endfunction

    task automatic send_sample(logic [SW-1:0] s, bit typed, avg_result_t typed_res);
        avg_result_t r;
        int gap;
        sample       <= s;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (sample_stall);
        r = filter_predict(s);
        pending_results.push_back(typed ? typed_res : r);
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 31) == 0)
            tx_quiet = !tx_quiet;
        // valid stays up when the next transfer follows at once
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle_block();
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_mode(bit v);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        avg_mode = v;
    endtask

    always @(posedge clk)
    begin
        avg_result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: mean %0d angle %0d",
                                 mean_value, angle_deg);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (mean_value !== want.mean || angle_deg !== want.angle)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: mean exp %0d got %0d, angle exp %0d got %0d",
                                     want.mean, mean_value, want.angle, angle_deg);
                    end
                end
                if ($urandom_range(0, 31) == 0)
                    rx_quiet = !rx_quiet;
                stall_left = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[adc_moving_average_to_angle] ERROR");
        $finish;
    end

    initial
    begin
        avg_result_t typed_res;
        int level;
        int run_len;
        int n;
        int k;
        int s;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
        begin
            if (dir_rows[i].avg != avg_mode)
            begin
                settle_block();
                write_mode(dir_rows[i].avg);
            end
            typed_res.mean  = SW'(dir_rows[i].mean);
            typed_res.angle = amaa_pkg::ANGLE_W'(dir_rows[i].angle);
            send_sample(SW'(dir_rows[i].smp), dir_rows[i].typed, typed_res);
        end

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            settle_block();
            write_mode((p < 2) ? bit'(p % 2) : bit'($urandom_range(0, 1)));
            n = 0;
            // runs around a level with jitter, broken by occasional outliers
            while (n < PHASE_ITEMS)
            begin
                level = pick_level();
                run_len = $urandom_range(1, 12);
                k = 0;
                while (k < run_len && n < PHASE_ITEMS)
                begin
                    if ($urandom_range(0, 4) == 0)
                        s = pick_level();
                    else
                        s = level + int'($urandom_range(0, 16)) - 8;
                    s = (s < 0) ? 0 : ((s > SMP_MAX) ? SMP_MAX : s);
                    send_sample(SW'(s), 1'b0, typed_res);
                    k++;
                    n++;
                end
            end
        end

        settle_block();
        if (pending_results.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("[adc_moving_average_to_angle] OK");
        else
            $display("[adc_moving_average_to_angle] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/amaa_pkg.sv
hdl/amaa_ctrl.sv
hdl/amaa_dp.sv
hdl/adc_moving_average_to_angle.sv
verif/testbench.sv
